[hdl/spa_pkg.sv]
package spa_pkg;

   localparam int MAX_TERMS = 16;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int COEF_W    = 32;
   localparam int EXPO_W    = 16;

   typedef enum logic [2:0] {
      CMD_CLEAR    = 3'd0,
      CMD_APPEND_A = 3'd1,
      CMD_APPEND_B = 3'd2,
      CMD_ADD      = 3'd3,
      CMD_SUB      = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_A_EMPTY    = 3'd1,
      STATUS_B_EMPTY    = 3'd2,
      STATUS_BOTH_EMPTY = 3'd3,
      STATUS_FULL       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_PASS_A,
      ST_PASS_B,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [EXPO_W-1:0] expo;
      logic signed [COEF_W-1:0] coef;
   } term_type;

   localparam int TERM_W = $bits(term_type);

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      term_type          data;
   } wr_type;

   typedef struct packed {
      logic       valid;
      term_type   term;
      status_type status;
      logic       last;
   } item_type;

   // clamp a 33-bit exact result to the signed 32-bit range
   function automatic logic signed [COEF_W-1:0] sat32(input logic signed [COEF_W:0] v);
      logic signed [COEF_W-1:0] r;
      if (v[COEF_W] != v[COEF_W-1]) begin
         r = v[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
         r = v[COEF_W-1:0];
      end
      return r;
   endfunction

endpackage

[hdl/spa_ram.sv]
module spa_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 48
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/spa_ctrl.sv]
module spa_ctrl import spa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2:0]               req_command,
   input  term_type                 req_term,
   input  logic                     out_ready,
   output logic [ADDR_W-1:0]        a_rd_addr,
   output logic [ADDR_W-1:0]        b_rd_addr,
   input  term_type                 a_rd_data,
   input  term_type                 b_rd_data,
   output wr_type                   a_wr,
   output wr_type                   b_wr,
   output item_type                 push
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] ia_ff, ia_in;
   logic [CNT_W-1:0] ib_ff, ib_in;
   logic             neg_ff, neg_in;
   logic             hold_valid_ff, hold_valid_in;
   term_type         hold_ff, hold_in;

   logic             fire;
   logic             a_valid, b_valid;
   logic             a_full, b_full;
   term_type         b_term;
   logic signed [COEF_W:0] a_ext, b_ext, comb_sum;
   logic signed [COEF_W-1:0] comb_sat;
   logic             produce, adv_a, adv_b, go_pass_a, go_pass_b, go_finish;
   term_type         prod_term;
   logic             stall;

   assign req_tready = (state_ff == ST_IDLE) && out_ready;
   assign fire       = req_tvalid && req_tready;

   assign a_valid = ia_ff < count_a_ff;
   assign b_valid = ib_ff < count_b_ff;
   assign a_full  = count_a_ff == CNT_W'(MAX_TERMS);
   assign b_full  = count_b_ff == CNT_W'(MAX_TERMS);

   // B term as it enters the result (negated for subtract)
   assign a_ext       = {a_rd_data.coef[COEF_W-1], a_rd_data.coef};
   assign b_ext       = {b_rd_data.coef[COEF_W-1], b_rd_data.coef};
   assign b_term.expo = b_rd_data.expo;
   assign b_term.coef = neg_ff ? sat32(-b_ext) : b_rd_data.coef;
   assign comb_sum    = neg_ff ? (a_ext - b_ext) : (a_ext + b_ext);
   assign comb_sat    = sat32(comb_sum);

   // one merge step
   always_comb begin
      produce   = 1'b0;
      adv_a     = 1'b0;
      adv_b     = 1'b0;
      go_pass_a = 1'b0;
      go_pass_b = 1'b0;
      go_finish = 1'b0;
      prod_term = a_rd_data;
      case (state_ff)
         ST_MERGE: begin
            if (!a_valid || a_rd_data.coef == '0) begin
               go_pass_b = 1'b1;
            end else if (!b_valid || b_rd_data.coef == '0) begin
               go_pass_a = 1'b1;
            end else if (a_rd_data.expo > b_rd_data.expo) begin
               produce = 1'b1;
               adv_a   = 1'b1;
            end else if (a_rd_data.expo < b_rd_data.expo) begin
               produce   = 1'b1;
               adv_b     = 1'b1;
               prod_term = b_term;
            end else begin
               produce        = comb_sat != '0;
               adv_a          = 1'b1;
               adv_b          = 1'b1;
               prod_term.coef = comb_sat;
            end
         end
         ST_PASS_A: begin
            if (a_valid) begin
               produce = 1'b1;
               adv_a   = 1'b1;
            end else begin
               go_finish = 1'b1;
            end
         end
         ST_PASS_B: begin
            if (b_valid) begin
               produce   = 1'b1;
               adv_b     = 1'b1;
               prod_term = b_term;
            end else begin
               go_finish = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // a new term pushes the held one out; wait if the output is busy
   assign stall = produce && hold_valid_ff && !out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire && (req_command == CMD_ADD || req_command == CMD_SUB) &&
                count_a_ff != '0 && count_b_ff != '0) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (go_pass_b) begin
               state_in = ST_PASS_B;
            end else if (go_pass_a) begin
               state_in = ST_PASS_A;
            end
         end
         ST_PASS_A, ST_PASS_B: begin
            if (go_finish) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      neg_in        = neg_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      a_wr.en       = 1'b0;
      a_wr.addr     = count_a_ff[ADDR_W-1:0];
      a_wr.data     = req_term;
      b_wr.en       = 1'b0;
      b_wr.addr     = count_b_ff[ADDR_W-1:0];
      b_wr.data     = req_term;
      push.valid    = 1'b0;
      push.term     = '0;
      push.status   = STATUS_OK;
      push.last     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            ia_in = '0;
            ib_in = '0;
            if (fire) begin
               case (req_command)
                  CMD_CLEAR: begin
                     count_a_in = '0;
                     count_b_in = '0;
                  end
                  CMD_APPEND_A: begin
                     push.valid = 1'b1;
                     if (a_full) begin
                        push.status = STATUS_FULL;
                     end else begin
                        a_wr.en    = 1'b1;
                        count_a_in = count_a_ff + 1'b1;
                     end
                  end
                  CMD_APPEND_B: begin
                     push.valid = 1'b1;
                     if (b_full) begin
                        push.status = STATUS_FULL;
                     end else begin
                        b_wr.en    = 1'b1;
                        count_b_in = count_b_ff + 1'b1;
                     end
                  end
                  CMD_ADD, CMD_SUB: begin
                     neg_in = req_command == CMD_SUB;
                     if (count_a_ff == '0 && count_b_ff == '0) begin
                        push.valid  = 1'b1;
                        push.status = STATUS_BOTH_EMPTY;
                     end else if (count_a_ff == '0) begin
                        push.valid  = 1'b1;
                        push.status = STATUS_A_EMPTY;
                     end else if (count_b_ff == '0) begin
                        push.valid  = 1'b1;
                        push.status = STATUS_B_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_ready) begin
               push.valid    = 1'b1;
               push.term     = hold_valid_ff ? hold_ff : '0;
               hold_valid_in = 1'b0;
            end
         end
         default: begin
            if (!stall) begin
               if (adv_a) begin
                  ia_in = ia_ff + 1'b1;
               end
               if (adv_b) begin
                  ib_in = ib_ff + 1'b1;
               end
               if (produce) begin
                  push.valid    = hold_valid_ff;
                  push.term     = hold_ff;
                  push.last     = 1'b0;
                  hold_in       = prod_term;
                  hold_valid_in = 1'b1;
               end
            end
         end
      endcase
   end

   // read addresses follow the next index so data lines up with the index register
   assign a_rd_addr = ia_in[ADDR_W-1:0];
   assign b_rd_addr = ib_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         ia_ff         <= '0;
         ib_ff         <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      hold_ff <= hold_in;
   end

   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_ready)
      else $error("item pushed while output register busy");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      ia_ff <= count_a_ff && ib_ff <= count_b_ff)
      else $error("merge index beyond store count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= CNT_W'(MAX_TERMS) && count_b_ff <= CNT_W'(MAX_TERMS))
      else $error("store count beyond capacity");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("pending term left over after command");

endmodule

[hdl/sparse_polynomial_add_subtract.sv]
// Sparse polynomial add / subtract.
// Commands arrive on the req_ stream, one item each: clear both stores, append
// a term to store A or B, add, or subtract. Stores hold up to MAX_TERMS terms
// each, expected in descending exponent order. Results leave on the rsp_
// stream; rsp_tlast marks the final item of a command.
// Clear gives no item. Append gives one item (status ok or store full) in
// the cycle after acceptance; appends can follow back to back while the
// receiver keeps up. Add/subtract with an empty store gives one status item.
// Otherwise the merge runs: the first terms are read in the accepting cycle,
// then each cycle is one merge step (a result term, or a combined pair that
// cancels and is dropped) unless the output stalls; entering the pass-through
// tail, leaving it and flushing the final term are steps of their own.
// One result term is held back so that tlast lands on the true final item.
// A new command is taken only once the previous command is complete.
// When the receiver stalls, the output register holds its item and a merge
// step that would push an item waits; nothing is dropped.
// Reset clears the counts and control; store contents are not cleared.
module sparse_polynomial_add_subtract import spa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coefficient[31:0], exponent[47:32]
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_coefficient[31:0], result_exponent[47:32]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast
);

   term_type          req_term;
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   term_type          a_rd_data, b_rd_data;
   wr_type            a_wr, b_wr;
   item_type          push;
   logic              out_ready;

   logic              rsp_valid_ff, rsp_valid_in;
   item_type          rsp_item_ff, rsp_item_in;

   assign req_term = req_tdata;

   spa_ram #(.DEPTH(MAX_TERMS), .WIDTH(TERM_W)) u_store_a (
      .clock   (clock),
      .wr_en   (a_wr.en),
      .wr_addr (a_wr.addr),
      .wr_data (a_wr.data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   spa_ram #(.DEPTH(MAX_TERMS), .WIDTH(TERM_W)) u_store_b (
      .clock   (clock),
      .wr_en   (b_wr.en),
      .wr_addr (b_wr.addr),
      .wr_data (b_wr.data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   spa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .req_term    (req_term),
      .out_ready   (out_ready),
      .a_rd_addr   (a_rd_addr),
      .b_rd_addr   (b_rd_addr),
      .a_rd_data   (a_rd_data),
      .b_rd_data   (b_rd_data),
      .a_wr        (a_wr),
      .b_wr        (b_wr),
      .push        (push)
   );

   // output register: free when empty or being taken this cycle
   assign out_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = push;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff.term;
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tlast  = rsp_item_ff.last;

endmodule

[tb/sv/tb_sparse_polynomial_add_subtract.sv]
`timescale 1ns / 1ps

module tb_sparse_polynomial_add_subtract;
   import spa_pkg::*;

   // Command codes the block ignores (no response item)
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   localparam int RANDOM_ITEMS = 250;
   localparam int DRAIN_CYCLES = 40;

   // One command item as the driver sends it. hold_for_drain makes the driver
   // wait until every outstanding response has come back before sending it.
   typedef struct {
      logic [2:0]        cmd;
      logic signed [31:0] coef;
      logic signed [15:0] expo;
      bit                hold_for_drain;
   } cmd_item;

   // One response term as the block should emit it
   typedef struct {
      term_type   term;
      status_type status;
      bit         last;
   } term_result;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // coefficient[31:0], exponent[47:32]
   logic [2:0]  req_tuser = '0;   // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // result_coefficient[31:0], result_exponent[47:32]
   logic [2:0]  rsp_tuser;       // status[2:0]
   logic        rsp_tlast;

   sparse_polynomial_add_subtract i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   cmd_item    pending_cmds[$];
   term_result expected_terms[$];
   cmd_item    in_flight;
   int         total_items = 1;
   int         items_sent = 0;
   int         mismatch_count = 0;

   // Shadow copy of the two term stores and their fill counts
   term_type poly_a[MAX_TERMS];
   term_type poly_b[MAX_TERMS];
   int       count_a = 0;
   int       count_b = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic signed [31:0] clamp_q16(longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[31:0];
   endfunction

   function automatic term_type make_term(logic signed [31:0] c, logic signed [15:0] e);
      term_type t;
      t.coef = c;
      t.expo = e;
      return t;
   endfunction

   // B term coefficient as seen by the merge; negated (saturating) for subtract
   function automatic logic signed [31:0] b_coef(int idx, bit negate);
      return negate ? clamp_q16(-longint'(poly_b[idx].coef)) : poly_b[idx].coef;
   endfunction

   // Update the shadow stores for one accepted command and queue the
   // response items it should produce.
   function automatic void predict_command(cmd_item it);
      term_result r;
      term_type   merged[$];
      int         ia;
      int         ib;
      bit         negate;
      longint     sum;
      r.term   = '0;
      r.status = STATUS_OK;
      r.last   = 1'b1;
      case (it.cmd)
         CMD_CLEAR: begin
            // counts only; store contents stay
            count_a = 0;
            count_b = 0;
         end
         CMD_APPEND_A: begin
            if (count_a >= MAX_TERMS) begin
               r.status = STATUS_FULL;
            end else begin
               poly_a[count_a] = make_term(it.coef, it.expo);
               count_a++;
            end
            expected_terms.push_back(r);
         end
         CMD_APPEND_B: begin
            if (count_b >= MAX_TERMS) begin
               r.status = STATUS_FULL;
            end else begin
               poly_b[count_b] = make_term(it.coef, it.expo);
               count_b++;
            end
            expected_terms.push_back(r);
         end
         CMD_ADD, CMD_SUB: begin
            if (count_a == 0 && count_b == 0) r.status = STATUS_BOTH_EMPTY;
            else if (count_a == 0)            r.status = STATUS_A_EMPTY;
            else if (count_b == 0)            r.status = STATUS_B_EMPTY;
            if (r.status != STATUS_OK) begin
               expected_terms.push_back(r);
            end else begin
               negate = (it.cmd == CMD_SUB);
               ia = 0;
               ib = 0;
               while (ia < count_a || ib < count_b) begin
                  // zero A term (or A used up): rest of B goes through (negated for subtract)
                  if (ia >= count_a || poly_a[ia].coef == 0) begin
                     while (ib < count_b) begin
                        merged.push_back(make_term(b_coef(ib, negate), poly_b[ib].expo));
                        ib++;
                     end
                     break;
                  end
                  // zero B term (or B used up): rest of A goes through
                  if (ib >= count_b || poly_b[ib].coef == 0) begin
                     while (ia < count_a) begin
                        merged.push_back(poly_a[ia]);
                        ia++;
                     end
                     break;
                  end
                  if ($signed(poly_a[ia].expo) > $signed(poly_b[ib].expo)) begin
                     merged.push_back(poly_a[ia]);
                     ia++;
                  end else if ($signed(poly_a[ia].expo) < $signed(poly_b[ib].expo)) begin
                     merged.push_back(make_term(b_coef(ib, negate), poly_b[ib].expo));
                     ib++;
                  end else begin
                     // same exponent: combine exactly, clamp, drop a zero sum
                     sum = negate ? longint'(poly_a[ia].coef) - longint'(poly_b[ib].coef)
                                  : longint'(poly_a[ia].coef) + longint'(poly_b[ib].coef);
                     if (sum != 0) merged.push_back(make_term(clamp_q16(sum), poly_a[ia].expo));
                     ia++;
                     ib++;
                  end
               end
               // nothing survived: the zero polynomial goes out as 0,0
               if (merged.size() == 0) merged.push_back('0);
               foreach (merged[k]) begin
                  r.term = merged[k];
                  r.last = (k == merged.size() - 1);
                  expected_terms.push_back(r);
               end
            end
         end
         default: ;   // spare codes are dropped without a response
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------

   task automatic push_cmd(logic [2:0] cmd, logic signed [31:0] coef = '0,
                           logic signed [15:0] expo = '0, bit hold = 1'b0);
      cmd_item it;
      it.cmd            = cmd;
      it.coef           = coef;
      it.expo           = expo;
      it.hold_for_drain = hold;
      pending_cmds.push_back(it);
   endtask

   // Coefficient mix: zeros, rails, whole numbers, near-rail values, anything
   function automatic logic signed [31:0] pick_coef();
      int sel;
      int whole;
      sel   = $urandom_range(0, 19);
      whole = $urandom_range(0, 64);
      case (sel)
         0:       return '0;
         1:       return Q_MAX;
         2:       return Q_MIN;
         3, 4:    return {3'b011, 29'($urandom())};
         5, 6:    return {3'b100, 29'($urandom())};
         7, 8, 9: return (whole - 32) * 65536;
         default: return $urandom();
      endcase
   endfunction

   // Store size mix: mostly short, some empty, some near, at or past capacity
   function automatic int pick_size();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 0;
      if (sel <= 2) return $urandom_range(12, MAX_TERMS + 2);
      return $urandom_range(1, 5);
   endfunction

   // Clear, load both stores (descending exponents unless scrambled, with
   // shared exponents so terms combine and cancel), then add and/or subtract.
   task automatic queue_merge_case(int na, int nb, bit scrambled, bit hold);
      shortint           exps_a[$];
      shortint           exps_b[$];
      logic signed [31:0] coefs_a[$];
      logic signed [31:0] c;
      int                base;
      int                span;
      int                ia;
      int                ib;
      int                pick;
      base = $urandom_range(0, 1) ? int'(shortint'($urandom())) : $urandom_range(0, 40) - 20;
      span = na + nb + 1;
      for (int k = 0; k < na; k++) begin
         exps_a.push_back(shortint'(base + int'($urandom_range(0, span))));
         coefs_a.push_back(pick_coef());
      end
      for (int k = 0; k < nb; k++) exps_b.push_back(shortint'(base + int'($urandom_range(0, span))));
      exps_a.rsort();
      exps_b.rsort();
      if (scrambled) begin
         exps_a.shuffle();
         exps_b.shuffle();
      end
      push_cmd(CMD_CLEAR);
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
            push_cmd(CMD_APPEND_A, coefs_a[ia], exps_a[ia]);
            ia++;
         end else begin
            c = pick_coef();
            // where A has the same exponent, often make the pair cancel
            foreach (exps_a[j]) begin
               if (exps_a[j] == exps_b[ib]) begin
                  pick = $urandom_range(0, 3);
                  if (pick == 0) c = coefs_a[j];        // cancels on subtract
                  else if (pick == 1) c = -coefs_a[j];  // cancels on add
               end
            end
            push_cmd(CMD_APPEND_B, c, exps_b[ib]);
            ib++;
         end
      end
      case ($urandom_range(0, 3))
         0: push_cmd(CMD_ADD, '0, '0, hold);
         1: push_cmd(CMD_SUB, '0, '0, hold);
         2: begin
            push_cmd(CMD_ADD, '0, '0, hold);
            push_cmd(CMD_SUB);
         end
         default: begin
            push_cmd(CMD_SUB, '0, '0, hold);
            push_cmd(CMD_ADD);
         end
      endcase
   endtask

   // Idle percentages per traffic phase: sender-heavy, receiver-heavy, none
   function automatic int idle_pct(bit receiver_side);
      int phase;
      phase = items_sent * 3 / total_items;
      if (phase == 0) return receiver_side ? 62 : 35;
      if (phase == 1) return receiver_side ? 35 : 62;
      return 0;
   endfunction

   // ------------------------------------------------------------------
   // Driver: feeds pending_cmds onto the req_ stream
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_command(in_flight);
            items_sent <= items_sent + 1;
         end
         // slot is free when nothing is offered or the offer was just taken
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0
                && !(pending_cmds[0].hold_for_drain && expected_terms.size() != 0)
                && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
               in_flight = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {in_flight.expo, in_flight.coef};
               req_tuser  <= in_flight.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver backpressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
   end

   // ------------------------------------------------------------------
   // Monitor: every accepted response against the oldest expected term
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      term_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_terms.size() == 0) begin
            $display("%0t: unexpected response item: coef %0d expo %0d status %0d last %0d",
                     $time, $signed(rsp_tdata[31:0]), $signed(rsp_tdata[47:32]),
                     rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_terms.pop_front();
            if (rsp_tdata[31:0] !== want.term.coef) begin
               $display("%0t: coefficient mismatch: expected %0d, actual %0d", $time,
                        $signed(want.term.coef), $signed(rsp_tdata[31:0]));
               mismatch_count++;
            end
            if (rsp_tdata[47:32] !== want.term.expo) begin
               $display("%0t: exponent mismatch: expected %0d, actual %0d", $time,
                        $signed(want.term.expo), $signed(rsp_tdata[47:32]));
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                        want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last mismatch: expected %0d, actual %0d", $time,
                        want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------

   initial begin
      int sel;

      // Directed: empty operands on each side
      push_cmd(CMD_ADD);                              // both stores empty
      push_cmd(CMD_APPEND_A, Q_MAX, 16'sh7fff);
      push_cmd(CMD_SUB);                              // B empty
      push_cmd(CMD_CLEAR);
      push_cmd(CMD_APPEND_B, Q_MIN, 16'sh8000);
      push_cmd(CMD_ADD);                              // A empty
      // exact cancellation -> zero polynomial, then negative rail
      push_cmd(CMD_APPEND_A, Q_MIN, 16'sh8000);
      push_cmd(CMD_SUB, '0, '0, 1'b1);
      push_cmd(CMD_ADD);
      // rail-to-rail combine, by subtract and by add
      push_cmd(CMD_CLEAR);
      push_cmd(CMD_APPEND_A, 5 * Q_ONE, 16'sd10);
      push_cmd(CMD_APPEND_A, Q_MAX, 16'sd3);
      push_cmd(CMD_APPEND_B, Q_MIN, 16'sd3);
      push_cmd(CMD_APPEND_B, Q_ONE, -16'sd1);
      push_cmd(CMD_SUB);
      push_cmd(CMD_ADD);
      // zero A term: B tail goes through (negated, zero term included)
      push_cmd(CMD_CLEAR);
      push_cmd(CMD_APPEND_A, '0, 16'sd7);
      push_cmd(CMD_APPEND_B, Q_MIN, 16'sd4);
      push_cmd(CMD_APPEND_B, '0, 16'sd1);
      push_cmd(CMD_SUB);
      // zero B term: A tail goes through
      push_cmd(CMD_CLEAR);
      push_cmd(CMD_APPEND_A, -2 * Q_ONE, 16'sd5);
      push_cmd(CMD_APPEND_A, Q_ONE, -16'sd3);
      push_cmd(CMD_APPEND_B, '0, 16'sd9);
      push_cmd(CMD_ADD);
      // spare codes
      push_cmd(CMD_SPARE_FIRST, $urandom(), 16'($urandom()));
      push_cmd(CMD_SPARE_LAST, $urandom(), 16'($urandom()), 1'b1);

      // Store A filled past capacity and B to capacity: store-full replies and the longest
      // merge, sent only after everything before it has drained.
      queue_merge_case(MAX_TERMS + 2, MAX_TERMS, 1'b0, 1'b1);

      while (pending_cmds.size() < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            // noise: any code, any payload, on whatever the stores hold
            repeat (3) push_cmd(3'($urandom_range(0, 7)), $urandom(), 16'($urandom()));
         end else begin
            queue_merge_case(pick_size(), pick_size(), sel == 1, sel == 2);
         end
      end
      total_items = pending_cmds.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_terms.size() != 0) @(posedge clock);
      // catch any stray items after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
